[hdl/perm_pkg.sv]
// ----------------------------------------------------------------------------
// Packet error rate monitor package
// Shared widths, constants, sequencer states and the structs passed between
// the sequencer and the shared divider.
// ----------------------------------------------------------------------------
package perm_pkg;

  localparam int SeqW        = 16;
  localparam int CountW      = 8;
  localparam int DigitW      = 4;
  localparam int DigitFields = 4;
  localparam int ProdW       = 12;
  localparam int StepW       = 4;

  localparam logic [CountW-1:0] LimitReset  = 8'd99;
  localparam logic [ProdW-1:0]  DecimalBase = 12'd10;
  localparam logic [StepW-1:0]  IntSteps    = 4'd8;
  localparam logic [StepW-1:0]  DigitSteps  = 4'd4;

  localparam logic KindStart  = 1'b0;
  localparam logic KindReport = 1'b1;

  typedef enum logic [1:0] {
    CtrlIdle,
    CtrlInt,
    CtrlDig,
    CtrlDone
  } perm_state_e;

  // Request to the shared divider
  typedef struct packed {
    logic              start;
    logic [7:0]        divisor;
    logic [7:0]        init_rem;
    logic [7:0]        init_bits;
    logic [StepW-1:0]  steps;
  } div_cmd_t;

  // Answer from the shared divider
  typedef struct packed {
    logic       done;
    logic [7:0] quot;
    logic [7:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic              report_kind;
    logic [CountW-1:0] received_count;
    logic [CountW-1:0] total_span;
    logic [CountW-1:0] lost_count;
    logic [CountW-1:0] integer_part;
    logic [DigitW-1:0] tenths_digit;
    logic [DigitW-1:0] hundredths_digit;
    logic [DigitW-1:0] thousandths_digit;
    logic [DigitW-1:0] ten_thousandths_digit;
    logic              divide_error;
  } result_t;

endpackage

[hdl/perm_if.sv]
// ----------------------------------------------------------------------------
// Packet error rate monitor channels
// Sequence number input, rate report output and window limit write channel.
// ----------------------------------------------------------------------------
interface perm_seq_if import perm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [SeqW-1:0] sequence_number;

  modport source (output valid, output sequence_number, input ready);
  modport sink   (input valid, input sequence_number, output ready);
endinterface

interface perm_rpt_if import perm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              report_kind;
  logic [CountW-1:0] received_count;
  logic [CountW-1:0] total_span;
  logic [CountW-1:0] lost_count;
  logic [CountW-1:0] integer_part;
  logic [DigitW-1:0] tenths_digit;
  logic [DigitW-1:0] hundredths_digit;
  logic [DigitW-1:0] thousandths_digit;
  logic [DigitW-1:0] ten_thousandths_digit;
  logic              divide_error;

  modport source (
    output valid, output report_kind, output received_count, output total_span,
    output lost_count, output integer_part, output tenths_digit,
    output hundredths_digit, output thousandths_digit,
    output ten_thousandths_digit, output divide_error, input ready
  );
  modport sink (
    input valid, input report_kind, input received_count, input total_span,
    input lost_count, input integer_part, input tenths_digit,
    input hundredths_digit, input thousandths_digit,
    input ten_thousandths_digit, input divide_error, output ready
  );
endinterface

interface perm_cfg_if import perm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] window_limit;

  modport source (output valid, output window_limit, input ready);
  modport sink   (input valid, input window_limit, output ready);
endinterface

[hdl/perm_div_unit.sv]
// ----------------------------------------------------------------------------
// Shared restoring divider
// Produces one quotient bit per cycle from an 8-bit divisor, a starting
// partial remainder and a left-aligned bit field of the dividend.
// ----------------------------------------------------------------------------
module perm_div_unit import perm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_cmd_t cmd_i,
  output div_rsp_t rsp_o
);

  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] steps_q;
  logic [7:0]       divisor_q;
  logic [7:0]       rem_q;
  logic [7:0]       bits_q;

  logic [8:0] trial;
  logic [8:0] diff;
  logic       fits;

  // Shift in the next dividend bit and try a subtract
  assign trial = {rem_q, bits_q[7]};
  assign diff  = trial - {1'b0, divisor_q};
  assign fits  = (trial >= {1'b0, divisor_q});

  // Step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      steps_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q  <= 1'b1;
        steps_q <= cmd_i.steps;
      end else if (busy_q) begin
        steps_q <= steps_q - 1'b1;
        if (steps_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      divisor_q <= cmd_i.divisor;
      rem_q     <= cmd_i.init_rem;
      bits_q    <= cmd_i.init_bits;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[7:0] : trial[7:0];
      bits_q <= {bits_q[6:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = bits_q;
  assign rsp_o.rem  = rem_q;

endmodule

[hdl/perm_ctrl.sv]
// ----------------------------------------------------------------------------
// Packet error rate sequencer
// Tracks the measurement window, forms span and loss, and drives the shared
// divider through the integer part and the decimal fraction digits.
// ----------------------------------------------------------------------------
module perm_ctrl import perm_pkg::*; #(
  parameter int FRACTION_DIGITS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [SeqW-1:0]   sequence_number_i,
  output logic              in_ready_o,
  input  logic [CountW-1:0] window_limit_i,
  output logic              res_valid_o,
  output result_t           res_o,
  input  logic              res_ready_i,
  output div_cmd_t          div_cmd_o,
  input  div_rsp_t          div_rsp_i
);

  localparam int IdxW = (FRACTION_DIGITS > 1) ? $clog2(FRACTION_DIGITS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FRACTION_DIGITS - 1);

  perm_state_e state_q, state_d;

  logic              in_window_q;
  logic [SeqW-1:0]   start_q;
  logic [CountW-1:0] count_q;
  logic [IdxW-1:0]   idx_q;

  logic              kind_q;
  logic [CountW-1:0] recv_q;
  logic [CountW-1:0] span_q;
  logic [CountW-1:0] lost_q;
  logic [CountW-1:0] int_q;
  logic [DigitW-1:0] digits_q [DigitFields];
  logic              err_q;

  logic              accept;
  logic [SeqW-1:0]   seq_dist;
  logic [CountW-1:0] count_inc;
  logic [CountW-1:0] span_calc;
  logic [CountW-1:0] lost_calc;
  logic              restart;
  logic [ProdW-1:0]  prod;

  // Window arithmetic for the incoming packet
  assign accept    = in_valid_i && (state_q == CtrlIdle);
  assign seq_dist  = sequence_number_i - start_q;
  assign count_inc = count_q + 1'b1;
  assign span_calc = seq_dist[CountW-1:0] + 1'b1;
  assign lost_calc = span_calc - count_inc;
  assign restart   = (sequence_number_i < start_q) ||
                     (seq_dist >= {{(SeqW-CountW){1'b0}}, window_limit_i});

  // Carry the remainder into the next decimal place
  assign prod = {4'b0, div_rsp_i.rem} * DecimalBase;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtrlIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and divider requests
  always_comb begin
    state_d   = state_q;
    div_cmd_o = '0;
    div_cmd_o.divisor = span_q;
    unique case (state_q)
      CtrlIdle: begin
        if (in_valid_i) begin
          if (!in_window_q || (span_calc == '0)) begin
            state_d = CtrlDone;
          end else begin
            div_cmd_o.start     = 1'b1;
            div_cmd_o.divisor   = span_calc;
            div_cmd_o.init_rem  = '0;
            div_cmd_o.init_bits = lost_calc;
            div_cmd_o.steps     = IntSteps;
            state_d = CtrlInt;
          end
        end
      end
      CtrlInt, CtrlDig: begin
        if (div_rsp_i.done) begin
          if ((state_q == CtrlDig) && (idx_q == LastIdx)) begin
            state_d = CtrlDone;
          end else begin
            div_cmd_o.start     = 1'b1;
            div_cmd_o.init_rem  = prod[ProdW-1:4];
            div_cmd_o.init_bits = {prod[3:0], 4'b0};
            div_cmd_o.steps     = DigitSteps;
            state_d = CtrlDig;
          end
        end
      end
      CtrlDone: begin
        if (res_ready_i) begin
          state_d = CtrlIdle;
        end
      end
      default: state_d = CtrlIdle;
    endcase
  end

  // Window state and digit index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_window_q <= 1'b0;
      start_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
    end else begin
      if (accept) begin
        idx_q <= '0;
        if (!in_window_q) begin
          in_window_q <= 1'b1;
          start_q     <= sequence_number_i;
          count_q     <= CountW'(1);
        end else begin
          count_q     <= count_inc;
          in_window_q <= !restart;
        end
      end else if ((state_q == CtrlDig) && div_rsp_i.done && (idx_q != LastIdx)) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // Result fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_window_q ? KindReport : KindStart;
      recv_q <= in_window_q ? count_inc : CountW'(1);
      span_q <= in_window_q ? span_calc : '0;
      lost_q <= in_window_q ? lost_calc : '0;
      int_q  <= '0;
      err_q  <= in_window_q && (span_calc == '0);
      for (int k = 0; k < DigitFields; k++) begin
        digits_q[k] <= '0;
      end
    end else if (div_rsp_i.done) begin
      if (state_q == CtrlInt) begin
        int_q <= div_rsp_i.quot;
      end else if (state_q == CtrlDig) begin
        for (int k = 0; k < DigitFields; k++) begin
          if ((k < FRACTION_DIGITS) && (idx_q == IdxW'(k))) begin
            digits_q[k] <= div_rsp_i.quot[DigitW-1:0];
          end
        end
      end
    end
  end

  assign in_ready_o  = (state_q == CtrlIdle);
  assign res_valid_o = (state_q == CtrlDone);

  assign res_o.report_kind           = kind_q;
  assign res_o.received_count        = recv_q;
  assign res_o.total_span            = span_q;
  assign res_o.lost_count            = lost_q;
  assign res_o.integer_part          = int_q;
  assign res_o.tenths_digit          = digits_q[0];
  assign res_o.hundredths_digit      = digits_q[1];
  assign res_o.thousandths_digit     = digits_q[2];
  assign res_o.ten_thousandths_digit = digits_q[3];
  assign res_o.divide_error          = err_q;

endmodule

[hdl/packet_error_rate_monitor.sv]
// ----------------------------------------------------------------------------
// Packet error rate monitor
// Counts received packets in a window of sequence numbers and reports the
// loss ratio as an integer part and decimal fraction digits.
// ----------------------------------------------------------------------------
// Usage:
//   seq_i  carries one sequence number per request. rpt_o returns exactly one
//   report per request: a window start report for the first packet of a
//   window, a rate report for every later one. cfg_i writes window_limit
//   and is always ready; write it only while no request is in flight.
//   The first packet of a window goes from accept straight to the done
//   state and then into the output register. For a rate report with nonzero
//   span one shared divider resolves 8 integer quotient bits, then 4 bits
//   per fraction digit, one bit per cycle. A zero span skips the divider
//   and goes straight to the done state with a divide error flagged.
//   seq_i.ready is low while a request is being worked on, so a new
//   request is not taken until the previous report has left the sequencer.
//   The output register holds a finished report while the sink stalls; the
//   next request is taken once that report sits in the register.
//   Reset clears the window (next packet opens a new one) and sets
//   window_limit to 99.
// ----------------------------------------------------------------------------
module packet_error_rate_monitor import perm_pkg::*; #(
  parameter int FRACTION_DIGITS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  perm_seq_if.sink   seq_i,
  perm_rpt_if.source rpt_o,
  perm_cfg_if.sink   cfg_i
);

  logic [CountW-1:0] limit_q;
  logic              out_valid_q;
  result_t           out_q;

  logic     res_valid;
  logic     res_ready;
  result_t  res;
  div_cmd_t div_cmd;
  div_rsp_t div_rsp;

  // Window limit register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.window_limit;
    end
  end

  perm_ctrl #(
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (seq_i.valid),
    .sequence_number_i (seq_i.sequence_number),
    .in_ready_o        (seq_i.ready),
    .window_limit_i    (limit_q),
    .res_valid_o       (res_valid),
    .res_o             (res),
    .res_ready_i       (res_ready),
    .div_cmd_o         (div_cmd),
    .div_rsp_i         (div_rsp)
  );

  perm_div_unit u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .rsp_o  (div_rsp)
  );

  // Output register: load a finished report when empty or draining
  assign res_ready = !out_valid_q || rpt_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rpt_o.valid                 = out_valid_q;
  assign rpt_o.report_kind           = out_q.report_kind;
  assign rpt_o.received_count        = out_q.received_count;
  assign rpt_o.total_span            = out_q.total_span;
  assign rpt_o.lost_count            = out_q.lost_count;
  assign rpt_o.integer_part          = out_q.integer_part;
  assign rpt_o.tenths_digit          = out_q.tenths_digit;
  assign rpt_o.hundredths_digit      = out_q.hundredths_digit;
  assign rpt_o.thousandths_digit     = out_q.thousandths_digit;
  assign rpt_o.ten_thousandths_digit = out_q.ten_thousandths_digit;
  assign rpt_o.divide_error          = out_q.divide_error;

endmodule
